// File: sv/wfq_pkg.sv
// shared types, constants and the arctangent table for the flow q-vector block
`default_nettype none
package wfq_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int SUM_BITS_DEF      = 40;

  localparam int TABLE_LEN   = 24;
  localparam int ITER_BITS   = 5;
  localparam int GAIN_BITS   = 30;
  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'h26DD3B6A;
  localparam int MAG_BITS    = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int CFG_DATA_BITS  = 4;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_HARMONIC_ORDER = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_ENABLE  = 1'd1;

  typedef struct packed {
    logic        has_track;
    logic [15:0] angle;
    logic [15:0] momentum;
    logic [15:0] track_weight;
    logic        event_end;
  } item_t;

  function automatic logic [31:0] atan_angle(input logic [ITER_BITS-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/wfq_front.sv
// front end: takes input beats, forms the harmonic angle and queues the items
`default_nettype none
module wfq_front #(
  parameter int ANGLE_BITS = wfq_pkg::ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        has_track,
  input  wire logic [15:0] azimuth,
  input  wire logic [15:0] momentum,
  input  wire logic [15:0] track_weight,
  input  wire logic        event_end,
  input  wire logic [3:0]  harmonic_order,
  output logic             item_valid,
  output wfq_pkg::item_t   item,
  input  wire logic        pop
);

  localparam int DROP16 = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;

  wfq_pkg::item_t q_mem [wfq_pkg::QUEUE_DEPTH];
  logic [wfq_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [wfq_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [wfq_pkg::QPTR_BITS:0]   count;
  logic [19:0] harm;
  logic [15:0] angle;
  logic push;
  wfq_pkg::item_t new_item;

  assign harm  = 20'(harmonic_order) * 20'(azimuth);
  assign angle = (harm[15:0] >> DROP16) << DROP16;
  assign in_ready   = (count != (wfq_pkg::QPTR_BITS+1)'(wfq_pkg::QUEUE_DEPTH));
  assign push       = in_valid & in_ready;
  assign item_valid = (count != '0);
  assign item       = q_mem[rd_ptr];

  always_comb begin
    new_item.has_track    = has_track;
    new_item.angle        = angle;
    new_item.momentum     = momentum;
    new_item.track_weight = track_weight;
    new_item.event_end    = event_end;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/wfq_back.sv
// back end: sin/cos cordic, saturating sums, end-of-event atan2 and magnitude
`default_nettype none
module wfq_back #(
  parameter int ANGLE_BITS    = wfq_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = wfq_pkg::CORDIC_STAGES_DEF,
  parameter int SUM_BITS      = wfq_pkg::SUM_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           weight_enable,
  input  wire logic           item_valid,
  input  wire wfq_pkg::item_t item,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic signed [15:0]  phase,
  output logic [wfq_pkg::MAG_BITS-1:0] magnitude,
  output logic                saturated
);

  localparam int ITERS = (CORDIC_STAGES < wfq_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                               : wfq_pkg::TABLE_LEN;
  localparam int NW    = (SUM_BITS > 46) ? SUM_BITS : 46;
  localparam int VW    = NW + 3;
  localparam int AW    = VW - 24 + wfq_pkg::GAIN_BITS;
  localparam int BW    = 24 + wfq_pkg::GAIN_BITS;
  localparam int DROP  = 32 - ANGLE_BITS;
  localparam int SH_R  = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SH_L  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [VW-1:0] MAG_MAX = VW'({wfq_pkg::MAG_BITS{1'b1}});

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_ROT    = 14'b00000000000010,
    ST_SCALE  = 14'b00000000000100,
    ST_MULC   = 14'b00000000001000,
    ST_MULS   = 14'b00000000010000,
    ST_ACCI   = 14'b00000000100000,
    ST_VSTART = 14'b00000001000000,
    ST_NORM   = 14'b00000010000000,
    ST_VEC    = 14'b00000100000000,
    ST_PH     = 14'b00001000000000,
    ST_MAGL   = 14'b00010000000000,
    ST_MAGS   = 14'b00100000000000,
    ST_DOWN   = 14'b01000000000000,
    ST_OUT    = 14'b10000000000000
  } state_t;

  state_t state;
  logic [wfq_pkg::ITER_BITS-1:0] cnt;
  logic        cur_end;
  logic [15:0] cur_mom;
  logic [15:0] cur_wt;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic flip;
  logic signed [15:0] cos_q, sin_q;
  logic [31:0] prod_p;
  logic        wsel;
  logic signed [48:0] prod;
  logic signed [SUM_BITS-1:0] sum_real, sum_imag;
  logic clip_seen;
  logic [NW-1:0] ax, ay, mx;
  logic sgnx, sgny;
  logic [5:0] lsh;
  logic signed [VW-1:0] vx, vy;
  logic [31:0] vz;
  logic [15:0] phase_r;
  logic [AW-1:0] mag_a;
  logic [BW-1:0] mag_b;
  logic [VW-1:0] t;
  logic sat_flag;

  logic [31:0] atan_v;
  logic signed [32:0] atan_s;
  logic signed [33:0] sdx, sdy, rx, ry;
  logic [31:0] a32;
  logic signed [VW-1:0] vdx, vdy;
  logic signed [48:0] term;
  logic [SUM_BITS-1:0] abs_r, abs_i;
  logic [VW-1:0] xm;
  logic [31:0] zr, qv, pv;
  logic [55:0] low_sum;
  logic last_iter;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [SUM_BITS:0] acc_add(input logic signed [SUM_BITS-1:0] acc,
                                                input logic signed [48:0] trm);
    logic signed [SUM_BITS:0] v;
    logic [SUM_BITS:0] r;
    v = {acc[SUM_BITS-1], acc} + signed'(trm[SUM_BITS:0]);
    // top bit of the result flags a clip
    if (v[SUM_BITS] != v[SUM_BITS-1]) begin
      r = {1'b1, v[SUM_BITS], {(SUM_BITS-1){~v[SUM_BITS]}}};
    end else begin
      r = {1'b0, v[SUM_BITS-1:0]};
    end
    return r;
  endfunction

  assign atan_v    = wfq_pkg::atan_angle(cnt);
  assign atan_s    = signed'({1'b0, atan_v});
  assign sdx       = cy >>> cnt;
  assign sdy       = cx >>> cnt;
  assign vdx       = vy >>> cnt;
  assign vdy       = vx >>> cnt;
  assign last_iter = (cnt == wfq_pkg::ITER_BITS'(ITERS - 1));
  assign a32       = {item.angle, 16'h0000};
  assign pop       = (state == ST_IDLE) && item_valid;

  always_comb begin
    rx = (cx + 34'sd16384) >>> 15;
    ry = (cy + 34'sd16384) >>> 15;
    if (flip) begin
      rx = -rx;
      ry = -ry;
    end
  end

  always_comb begin
    if (wsel) begin
      term = (prod + 49'sd67108864) >>> 27;
    end else begin
      term = (prod + 49'sd16384) >>> 15;
    end
  end

  assign abs_r   = sum_real[SUM_BITS-1] ? SUM_BITS'(-sum_real) : SUM_BITS'(sum_real);
  assign abs_i   = sum_imag[SUM_BITS-1] ? SUM_BITS'(-sum_imag) : SUM_BITS'(sum_imag);
  assign xm      = vx[VW-1] ? '0 : VW'(vx);
  assign zr      = vz + (32'd1 << (DROP - 1));
  assign qv      = zr >> DROP;
  assign pv      = (qv >> SH_R) << SH_L;
  assign low_sum = 56'({mag_a[5:0], 24'h000000}) + 56'(mag_b) + (56'd1 << 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      sum_real  <= '0;
      sum_imag  <= '0;
      clip_seen <= 1'b0;
      out_valid <= 1'b0;
      lsh       <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur_end   <= item.event_end;
            cur_mom   <= item.momentum;
            cur_wt    <= item.track_weight;
            flip      <= a32[31] ^ a32[30];
            cx        <= 34'(wfq_pkg::GAIN_Q30);
            cy        <= '0;
            // the half turn fold leaves bit 30 as the sign of the residual angle
            cz        <= signed'({a32[30], a32[30], a32[30:0]});
            cnt       <= '0;
            if (item.has_track) begin
              state <= ST_ROT;
            end else if (item.event_end) begin
              state <= ST_VSTART;
            end
          end
        end
        ST_ROT: begin
          if (cz >= 0) begin
            cx <= cx - sdx;
            cy <= cy + sdy;
            cz <= cz - atan_s;
          end else begin
            cx <= cx + sdx;
            cy <= cy - sdy;
            cz <= cz + atan_s;
          end
          cnt <= cnt + 1'b1;
          if (last_iter) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          cos_q  <= sat16(rx);
          sin_q  <= sat16(ry);
          wsel   <= weight_enable;
          prod_p <= weight_enable ? 32'(cur_mom) * 32'(cur_wt) : 32'(cur_mom);
          state  <= ST_MULC;
        end
        ST_MULC: begin
          prod  <= signed'({1'b0, prod_p}) * 49'(cos_q);
          state <= ST_MULS;
        end
        ST_MULS: begin
          prod <= signed'({1'b0, prod_p}) * 49'(sin_q);
          {clip_seen, sum_real} <= {clip_seen, {SUM_BITS{1'b0}}} |
                                   {1'b0, {SUM_BITS{1'b0}}} | acc_add(sum_real, term);
          state <= ST_ACCI;
        end
        ST_ACCI: begin
          {clip_seen, sum_imag} <= {clip_seen, {SUM_BITS{1'b0}}} | acc_add(sum_imag, term);
          state <= cur_end ? ST_VSTART : ST_IDLE;
        end
        ST_VSTART: begin
          ax        <= NW'(abs_r);
          ay        <= NW'(abs_i);
          mx        <= (abs_r > abs_i) ? NW'(abs_r) : NW'(abs_i);
          sgnx      <= sum_real[SUM_BITS-1];
          sgny      <= sum_imag[SUM_BITS-1];
          sat_flag  <= clip_seen;
          sum_real  <= '0;
          sum_imag  <= '0;
          clip_seen <= 1'b0;
          lsh       <= '0;
          if (abs_r == '0 && abs_i == '0) begin
            phase_r <= '0;
            t       <= '0;
            state   <= ST_DOWN;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (!(|mx[NW-1:45])) begin
            ax  <= ax << 1;
            ay  <= ay << 1;
            mx  <= mx << 1;
            lsh <= lsh + 1'b1;
          end else begin
            vx    <= signed'(VW'(ax));
            vy    <= (sgnx ^ sgny) ? -signed'(VW'(ay)) : signed'(VW'(ay));
            vz    <= sgnx ? 32'h80000000 : 32'h0;
            cnt   <= '0;
            state <= ST_VEC;
          end
        end
        ST_VEC: begin
          if (vy >= 0) begin
            vx <= vx + vdx;
            vy <= vy - vdy;
            vz <= vz + atan_v;
          end else begin
            vx <= vx - vdx;
            vy <= vy + vdy;
            vz <= vz - atan_v;
          end
          cnt <= cnt + 1'b1;
          if (last_iter) begin
            state <= ST_PH;
          end
        end
        ST_PH: begin
          phase_r <= pv[15:0];
          mag_a   <= AW'(xm[VW-1:24]) * AW'(wfq_pkg::GAIN_Q30);
          state   <= ST_MAGL;
        end
        ST_MAGL: begin
          mag_b <= BW'(xm[23:0]) * BW'(wfq_pkg::GAIN_Q30);
          state <= ST_MAGS;
        end
        ST_MAGS: begin
          t     <= VW'(mag_a >> 6) + VW'(low_sum[55:30]);
          state <= ST_DOWN;
        end
        ST_DOWN: begin
          // shift back one bit a beat, rounding on the last
          if (lsh > 6'd1) begin
            t   <= t >> 1;
            lsh <= lsh - 1'b1;
          end else if (lsh == 6'd1) begin
            t   <= (t + 1'b1) >> 1;
            lsh <= '0;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            phase     <= signed'(phase_r);
            magnitude <= (t > MAG_MAX) ? MAG_MAX[wfq_pkg::MAG_BITS-1:0]
                                       : t[wfq_pkg::MAG_BITS-1:0];
            saturated <= sat_flag;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/weighted_flow_q_vector.sv
// top level of the weighted harmonic flow q-vector block
//
//   channel   direction  handshake               payload
//   in        in         in_valid / in_ready     has_track azimuth momentum track_weight event_end
//   out       out        out_valid / out_ready   phase magnitude saturated
//   cfg       in         cfg_write               cfg_index cfg_data
//
// a track beat holds the back end for the rotation (one rotation per cycle), the scale step,
// the two multiplies and the two sums; an event end adds a start step, the normalising shifts,
// the vectoring rotations, the gain multiply (ST_PH, ST_MAGL, ST_MAGS), the shift back and an out step
// a four-entry queue lets the front keep taking beats while the back is busy
// rst is synchronous; it empties the queue, clears the sums and drops out_valid
`default_nettype none
module weighted_flow_q_vector #(
  parameter int ANGLE_BITS    = wfq_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = wfq_pkg::CORDIC_STAGES_DEF,
  parameter int SUM_BITS      = wfq_pkg::SUM_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [wfq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [wfq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        has_track,
  input  wire logic [15:0] azimuth,
  input  wire logic [15:0] momentum,
  input  wire logic [15:0] track_weight,
  input  wire logic        event_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] phase,
  output logic [wfq_pkg::MAG_BITS-1:0] magnitude,
  output logic             saturated
);

  logic [3:0] harmonic_order;
  logic       weight_enable;
  logic       item_valid;
  logic       pop;
  wfq_pkg::item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      harmonic_order <= 4'd1;
      weight_enable  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        wfq_pkg::REG_HARMONIC_ORDER: harmonic_order <= cfg_data[3:0];
        wfq_pkg::REG_WEIGHT_ENABLE:  weight_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  wfq_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .has_track(has_track),
    .azimuth(azimuth),
    .momentum(momentum),
    .track_weight(track_weight),
    .event_end(event_end),
    .harmonic_order(harmonic_order),
    .item_valid(item_valid),
    .item(item),
    .pop(pop)
  );

  wfq_back #(
    .ANGLE_BITS(ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .SUM_BITS(SUM_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .weight_enable(weight_enable),
    .item_valid(item_valid),
    .item(item),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .phase(phase),
    .magnitude(magnitude),
    .saturated(saturated)
  );

endmodule
`default_nettype wire

// File: sv/wfq_check.sv
// port checker for the flow q-vector block and its bind
`default_nettype none
module wfq_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic signed [15:0] phase,
  input wire logic [wfq_pkg::MAG_BITS-1:0] magnitude,
  input wire logic        saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(phase) && $stable(magnitude) && $stable(saturated))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not empty the block");

endmodule

bind weighted_flow_q_vector wfq_check u_check (.*);
`default_nettype wire
